[design/wblsc_pkg.sv]
// Package for the write-back LRU sector cache controller.
// Holds request and result codes, register indexes and the line entry type.
`timescale 1ns / 1ps
`default_nettype none
package wblsc_pkg;
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;
  localparam logic [1:0] REQ_INVAL = 2'd3;

  localparam logic [2:0] RES_DONE  = 3'd0;
  localparam logic [2:0] RES_WBACK = 3'd1;
  localparam logic [2:0] RES_FILL  = 3'd2;
  localparam logic [2:0] RES_DFLSH = 3'd3;
  localparam logic [2:0] RES_ERROR = 3'd4;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_BASE   = 2'd1;
  localparam logic [1:0] REG_SIZE   = 2'd2;

  typedef struct packed {
    logic        dirty;
    logic [63:0] tag;
    logic [31:0] stamp;
  } line_t;

  localparam int LINE_W = $bits(line_t);
endpackage
`default_nettype wire

[design/wblsc_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on nothing but its own ports.
`timescale 1ns / 1ps
`default_nettype none
interface wblsc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] sector;
  modport source (output valid, req_type, sector, input ready);
  modport sink (input valid, req_type, sector, output ready);
endinterface

interface wblsc_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [4:0]  line_index;
  logic [63:0] device_sector;
  logic        was_hit;
  logic        last_result;
  modport source (output valid, result_kind, line_index, device_sector, was_hit,
                  last_result, input ready);
  modport sink (input valid, result_kind, line_index, device_sector, was_hit,
                last_result, output ready);
endinterface
`default_nettype wire

[design/wblsc_ram.sv]
// Generic single-port-write, one-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module wblsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/write_back_lru_sector_cache_ctrl.sv]
// Top level of the write-back LRU sector cache controller.
// Depends on wblsc_pkg, wblsc_if and wblsc_ram.
//
// Usage: requests enter on the req channel (req_type, sector), results leave
// on the res channel, each a valid/ready transaction. Registers are written
// through cfg_we/cfg_index/cfg_data while the block is idle.
// Line entries (dirty, tag, use stamp) sit in one RAM with a registered read;
// valid bits sit in flip-flops so that reset and invalidate clear them at once.
// A read or write scans every line, one RAM read a cycle, to find a hit and
// the victim, then re-reads the chosen line; a dirty victim is written back
// before the fill.
// A flush scans all lines likewise, emitting a writeback per valid dirty line
// during the scan. Errors and invalidate are answered on acceptance.
// One request is in work at a time.
// Results wait in an output register; when the receiver stalls, the flush scan
// stops at a line that needs a writeback and the result steps hold until the
// register is taken; no new request is accepted. Reset clears the valid bits,
// the use clock and the registers; the block takes requests from the next cycle.
`timescale 1ns / 1ps
`default_nettype none
module write_back_lru_sector_cache_ctrl #(
  parameter int LINES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  wblsc_req_if.sink        req,
  wblsc_res_if.source      res
);
  localparam int IW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] LAST = CW'(LINES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_FSCAN = 3'd5;
  localparam logic [2:0] S_FEND  = 3'd6;
  localparam logic [2:0] S_WAIT  = 3'd7;

  logic        enabled;
  logic [63:0] base, size;
  logic [2:0]  state;
  logic [1:0]  rtype;
  logic [63:0] rsec;
  logic [31:0] use_ctr;
  logic [LINES-1:0] valid;

  // Scan pointers: raddr issued, cidx is the line whose data is on rdata.
  logic [CW-1:0] ptr;
  logic [IW-1:0] cidx;
  logic          cval;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic          inv_found;
  logic [IW-1:0] inv_idx;
  logic [IW-1:0] best_idx;
  logic [31:0]   best_use;
  logic          best_dirty;
  logic [IW-1:0] line;

  // Output register.
  logic        ovalid;
  logic [2:0]  okind;
  logic [4:0]  oline;
  logic [63:0] osec;
  logic        ohit, olast;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  wblsc_pkg::line_t wdata, rd;
  logic [wblsc_pkg::LINE_W-1:0] rdata;

  assign rd = wblsc_pkg::line_t'(rdata);

  wblsc_ram #(.WIDTH(wblsc_pkg::LINE_W), .DEPTH(LINES)) u_lines (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [31:0] use1, use2;
  assign use1 = (use_ctr == 32'hFFFF_FFFF) ? 32'd1 : use_ctr + 32'd1;
  assign use2 = (use1 == 32'hFFFF_FFFF) ? 32'd1 : use1 + 32'd1;

  logic out_free;
  assign out_free = !ovalid || res.ready;
  assign req.ready = (state == S_IDLE) && out_free;

  assign res.valid = ovalid;
  assign res.result_kind = okind;
  assign res.line_index = oline;
  assign res.device_sector = osec;
  assign res.was_hit = ohit;
  assign res.last_result = olast;

  // Flush: current scanned entry needs a writeback.
  logic fl_wb;
  assign fl_wb = cval && valid[cidx] && rd.dirty;

  // RAM write for the current step.
  always_comb begin
    we = 1'b0;
    waddr = cidx;
    wdata = rd;
    unique case (state)
      S_FSCAN: begin
        if (fl_wb && out_free) begin
          we = 1'b1;
          wdata.dirty = 1'b0;
        end
      end
      S_FILL: begin
        if (out_free) begin
          we = 1'b1;
          waddr = line;
          wdata.tag = rsec;
          wdata.dirty = hit ? best_dirty : 1'b0;
          if (rtype == wblsc_pkg::REQ_WRITE) begin
            wdata.dirty = 1'b1;
            wdata.stamp = use2;
          end else begin
            wdata.stamp = use1;
          end
        end
      end
      default: ;
    endcase
  end

  logic scan_step;
  assign scan_step = (state == S_SCAN) || (state == S_FSCAN && (!fl_wb || out_free));

  // A stalled flush step keeps re-reading the entry it is waiting on.
  assign raddr = (state == S_FSCAN && !scan_step) ? cidx : ptr[IW-1:0];

  // The output register is loaded in this cycle.
  logic oload;
  always_comb begin
    unique case (state)
      S_IDLE: oload = req.valid && req.ready &&
                      (!enabled || size == 64'd0 ||
                       req.req_type == wblsc_pkg::REQ_INVAL ||
                       (req.req_type != wblsc_pkg::REQ_FLUSH && req.sector >= size));
      S_FILL:  oload = out_free && !hit;
      S_DONE:  oload = out_free;
      S_FEND:  oload = out_free;
      S_FSCAN: oload = cval && fl_wb && out_free;
      default: oload = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      base <= '0;
      size <= '0;
      state <= S_IDLE;
      use_ctr <= '0;
      valid <= '0;
      ovalid <= 1'b0;
      cval <= 1'b0;
      ptr <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          wblsc_pkg::REG_ENABLE: enabled <= cfg_data[0];
          wblsc_pkg::REG_BASE:   base <= cfg_data;
          wblsc_pkg::REG_SIZE:   size <= cfg_data;
          default: ;
        endcase
      end
      if (ovalid && res.ready && !oload) ovalid <= 1'b0;

      // Scan pipeline: read address advances, data arrives in the cycle after.
      if (scan_step) begin
        cval <= (ptr <= LAST);
        cidx <= ptr[IW-1:0];
        if (ptr <= LAST) ptr <= ptr + CW'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            rtype <= req.req_type;
            rsec <= req.sector;
            ptr <= '0;
            cval <= 1'b0;
            hit <= 1'b0;
            inv_found <= 1'b0;
            best_use <= 32'hFFFF_FFFF;
            best_idx <= '0;
            if (!enabled || size == 64'd0) begin
              ovalid <= 1'b1; okind <= wblsc_pkg::RES_ERROR; oline <= '0;
              osec <= '0; ohit <= 1'b0; olast <= 1'b1;
            end else if (req.req_type == wblsc_pkg::REQ_INVAL) begin
              valid <= '0;
              use_ctr <= '0;
              ovalid <= 1'b1; okind <= wblsc_pkg::RES_DONE; oline <= '0;
              osec <= '0; ohit <= 1'b0; olast <= 1'b1;
            end else if (req.req_type == wblsc_pkg::REQ_FLUSH) begin
              state <= S_FSCAN;
            end else if (req.sector >= size) begin
              ovalid <= 1'b1; okind <= wblsc_pkg::RES_ERROR; oline <= '0;
              osec <= '0; ohit <= 1'b0; olast <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cval) begin
            if (valid[cidx] && rd.tag == rsec && !hit) begin
              hit <= 1'b1; hit_idx <= cidx; best_dirty <= rd.dirty;
            end
            if (!valid[cidx] && !inv_found) begin
              inv_found <= 1'b1; inv_idx <= cidx;
            end
            if (valid[cidx] && (cidx == '0 || rd.stamp < best_use)) begin
              best_use <= rd.stamp; best_idx <= cidx;
            end
            if ({1'b0, cidx} == LAST) state <= S_DEC;
          end
        end
        S_DEC: begin
          // Re-read the chosen entry (hit or victim) to get its dirty bit and tag.
          line <= hit ? hit_idx : (inv_found ? inv_idx : best_idx);
          ptr <= {1'b0, hit ? hit_idx : (inv_found ? inv_idx : best_idx)};
          state <= S_WAIT;
        end
        S_WAIT: begin
          state <= S_FILL;
        end
        S_FILL: begin
          if (out_free) begin
            if (!hit) begin
              valid[line] <= 1'b1;
              if (valid[line] && rd.dirty) begin
                ovalid <= 1'b1; okind <= wblsc_pkg::RES_WBACK;
                oline <= 5'(line); osec <= base + rd.tag;
                ohit <= 1'b0; olast <= 1'b0;
                state <= S_DONE;
                best_dirty <= 1'b1;
              end else begin
                ovalid <= 1'b1; okind <= wblsc_pkg::RES_FILL;
                oline <= 5'(line); osec <= base + rsec;
                ohit <= 1'b0; olast <= 1'b0;
                state <= S_DONE;
                best_dirty <= 1'b0;
              end
            end else begin
              state <= S_DONE;
              best_dirty <= 1'b0;
            end
            use_ctr <= (rtype == wblsc_pkg::REQ_WRITE) ? use2 : use1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            ovalid <= 1'b1;
            oline <= 5'(line);
            osec <= base + rsec;
            ohit <= 1'b0;
            if (best_dirty) begin
              okind <= wblsc_pkg::RES_FILL; olast <= 1'b0;
              best_dirty <= 1'b0;
            end else begin
              okind <= wblsc_pkg::RES_DONE; ohit <= hit; olast <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_FSCAN: begin
          if (cval && fl_wb && out_free) begin
            ovalid <= 1'b1; okind <= wblsc_pkg::RES_WBACK;
            oline <= 5'(cidx); osec <= base + rd.tag;
            ohit <= 1'b0; olast <= 1'b0;
          end
          if (cval && {1'b0, cidx} == LAST && (!fl_wb || out_free)) state <= S_FEND;
        end
        S_FEND: begin
          if (out_free) begin
            ovalid <= 1'b1; okind <= wblsc_pkg::RES_DFLSH; oline <= '0;
            osec <= '0; ohit <= 1'b0; olast <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/wblsc_checker.sv]
// Port-level checker for the sector cache controller, bound to the top level.
// Depends on wblsc_pkg for result codes.
`timescale 1ns / 1ps
`default_nettype none
module wblsc_port_checks (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [2:0]  res_kind,
  input wire logic        res_last,
  input wire logic        res_hit
);
  // A stalled result holds its kind.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_kind))
    else $error("result changed under stall");
  // Errors and device flushes close a request.
  a_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_kind == wblsc_pkg::RES_ERROR || res_kind == wblsc_pkg::RES_DFLSH)
    |-> res_last) else $error("terminal result not last");
  // Only a done result may report a hit.
  a_hit: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_hit |-> res_kind == wblsc_pkg::RES_DONE && res_last)
    else $error("hit on non-done result");
  // Writebacks and fills are never last.
  a_mid: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_kind == wblsc_pkg::RES_WBACK || res_kind == wblsc_pkg::RES_FILL)
    |-> !res_last) else $error("command marked last");
endmodule

bind write_back_lru_sector_cache_ctrl wblsc_port_checks u_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .res_valid(res.valid), .res_ready(res.ready), .res_kind(res.result_kind),
  .res_last(res.last_result), .res_hit(res.was_hit)
);
`default_nettype wire

[test/wblsc_checker.sv]
// Checker for the write-back LRU sector cache controller.
// Depends on wblsc_pkg and wblsc_if; predicts results and compares them.
`timescale 1ns / 1ps
`default_nettype none
module wblsc_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  wblsc_req_if             req,
  wblsc_res_if             res,
  output int               fail_count,
  output int               pending
);
  localparam int NLINES = 32;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  line;
    logic [63:0] dsec;
    logic        hit;
    logic        last;
  } cache_result_t;

  // Shadow copy of the controller state and registers.
  logic         enabled;
  logic [63:0]  base;
  logic [63:0]  size;
  logic         sh_valid [NLINES];
  logic         sh_dirty [NLINES];
  logic [63:0]  sh_tag [NLINES];
  logic [31:0]  sh_use [NLINES];
  logic [31:0]  lru_clock;
  cache_result_t expected_results[$];

  function automatic void clear_lines();
    for (int i = 0; i < NLINES; i++) begin
      sh_valid[i] = 1'b0;
      sh_dirty[i] = 1'b0;
      sh_tag[i]   = '0;
      sh_use[i]   = '0;
    end
    lru_clock = '0;
  endfunction

  function automatic void touch_line(int i);
    lru_clock = lru_clock + 32'd1;
    if (lru_clock == 32'd0) lru_clock = 32'd1;
    sh_use[i] = lru_clock;
  endfunction

  function automatic void push_result(logic [2:0] k, int l, logic [63:0] d, logic h,
                                      logic lst);
    cache_result_t r;
    r.kind = k;
    r.line = l[4:0];
    r.dsec = d;
    r.hit  = h;
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  // Works out every result that one request causes, updating the shadow state.
  function automatic void predict_request(logic [1:0] kind, logic [63:0] sec);
    int line;
    logic hit;
    line = -1;
    hit  = 1'b0;
    if (!enabled || size == 64'd0) begin
      push_result(wblsc_pkg::RES_ERROR, 0, '0, 1'b0, 1'b1);
    end else if (kind == wblsc_pkg::REQ_INVAL) begin
      clear_lines();
      push_result(wblsc_pkg::RES_DONE, 0, '0, 1'b0, 1'b1);
    end else if (kind == wblsc_pkg::REQ_FLUSH) begin
      for (int i = 0; i < NLINES; i++) begin
        if (sh_valid[i] && sh_dirty[i]) begin
          push_result(wblsc_pkg::RES_WBACK, i, base + sh_tag[i], 1'b0, 1'b0);
          sh_dirty[i] = 1'b0;
        end
      end
      push_result(wblsc_pkg::RES_DFLSH, 0, '0, 1'b0, 1'b1);
    end else if (sec >= size) begin
      push_result(wblsc_pkg::RES_ERROR, 0, '0, 1'b0, 1'b1);
    end else begin
      for (int i = 0; i < NLINES; i++) begin
        if (line < 0 && sh_valid[i] && sh_tag[i] == sec) line = i;
      end
      if (line >= 0) begin
        hit = 1'b1;
        touch_line(line);
      end else begin
        // Victim: first invalid line, else oldest use with lowest index on ties.
        line = 0;
        for (int i = 0; i < NLINES; i++) begin
          if (!sh_valid[i]) begin
            line = i;
            break;
          end
          if (sh_use[i] < sh_use[line]) line = i;
        end
        if (sh_valid[line] && sh_dirty[line])
          push_result(wblsc_pkg::RES_WBACK, line, base + sh_tag[line], 1'b0, 1'b0);
        push_result(wblsc_pkg::RES_FILL, line, base + sec, 1'b0, 1'b0);
        sh_valid[line] = 1'b1;
        sh_dirty[line] = 1'b0;
        sh_tag[line]   = sec;
        touch_line(line);
      end
      if (kind == wblsc_pkg::REQ_WRITE) begin
        sh_dirty[line] = 1'b1;
        touch_line(line);
      end
      push_result(wblsc_pkg::RES_DONE, line, base + sec, hit, 1'b1);
    end
  endfunction

  // Track register writes and requests, and compare each result transaction.
  always @(posedge clk) begin
    cache_result_t exp_r;
    if (rst) begin
      clear_lines();
      enabled = 1'b0;
      base    = '0;
      size    = '0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wblsc_pkg::REG_ENABLE: enabled = cfg_data[0];
          wblsc_pkg::REG_BASE:   base = cfg_data;
          wblsc_pkg::REG_SIZE:   size = cfg_data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) predict_request(req.req_type, req.sector);
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction kind=%0d", res.result_kind);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (res.result_kind !== exp_r.kind ||
              res.line_index !== exp_r.line ||
              res.device_sector !== exp_r.dsec ||
              res.was_hit !== exp_r.hit ||
              res.last_result !== exp_r.last)
            fail_count <= fail_count + 1;
          if (res.result_kind !== exp_r.kind)
            $error("result_kind: expected %0d, got %0d", exp_r.kind, res.result_kind);
          if (res.line_index !== exp_r.line)
            $error("line_index: expected %0d, got %0d", exp_r.line, res.line_index);
          if (res.device_sector !== exp_r.dsec)
            $error("device_sector: expected %h, got %h", exp_r.dsec, res.device_sector);
          if (res.was_hit !== exp_r.hit)
            $error("was_hit: expected %0b, got %0b", exp_r.hit, res.was_hit);
          if (res.last_result !== exp_r.last)
            $error("last_result: expected %0b, got %0b", exp_r.last, res.last_result);
        end
      end
    end
    pending <= expected_results.size();
  end
endmodule
`default_nettype wire

[test/tb.sv]
// Testbench top for the write-back LRU sector cache controller.
// Depends on wblsc_pkg, wblsc_if, wblsc_checker and the block itself.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = wblsc_pkg::REG_ENABLE;
  logic [63:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  logic        quiet_phase = 1'b0;
  logic        hold_off = 1'b0;
  int          idle_cycles = 0;

  wblsc_req_if req();
  wblsc_res_if res();

  write_back_lru_sector_cache_ctrl u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req), .res(res)
  );

  wblsc_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req), .res(res), .fail_count(fail_count),
    .pending(pending)
  );

  always #1 clk = ~clk;

  // Receiver: random stall bursts, a long hold-off when asked, none at the end.
  always @(posedge clk) begin
    int n;
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_off) begin
      res.ready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 9);
      res.ready <= 1'b0;
      repeat (n) @(posedge clk);
      res.ready <= 1'b1;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // Watchdog: counts cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (res.valid && res.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("write_back_lru_sector_cache_ctrl verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for all results, then a margin so that the block is surely idle.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Offers one request; idles before it at random unless in the quiet phase.
  task automatic send_request(logic [1:0] kind, logic [63:0] sec);
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.req_type <= kind;
    req.sector   <= sec;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic end_burst();
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random request kind: mostly reads and writes, some flushes, a few invalidates.
  function automatic logic [1:0] rand_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return wblsc_pkg::REQ_READ;
    if (r < 88) return wblsc_pkg::REQ_WRITE;
    if (r < 96) return wblsc_pkg::REQ_FLUSH;
    return wblsc_pkg::REQ_INVAL;
  endfunction

  initial begin
    logic [63:0] size_v;
    req.valid    <= 1'b0;
    req.req_type <= wblsc_pkg::REQ_READ;
    req.sector   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Disabled block, then enabled with zero size: every request is an error.
    send_request(wblsc_pkg::REQ_READ, 64'd0);
    send_request(wblsc_pkg::REQ_INVAL, '1);
    end_burst();
    drain();
    write_reg(wblsc_pkg::REG_ENABLE, 64'd1);
    send_request(wblsc_pkg::REQ_WRITE, 64'd3);
    end_burst();
    drain();

    // Full-range partition with a top base: sector and address extremes.
    write_reg(wblsc_pkg::REG_BASE, '1);
    write_reg(wblsc_pkg::REG_SIZE, '1);
    send_request(wblsc_pkg::REQ_WRITE, 64'd0);
    send_request(wblsc_pkg::REQ_READ, 64'hFFFF_FFFF_FFFF_FFFE);
    send_request(wblsc_pkg::REQ_READ, '1);
    send_request(wblsc_pkg::REQ_READ, 64'd0);
    send_request(wblsc_pkg::REQ_WRITE, 64'h5555_AAAA_5555_AAAA);
    send_request(wblsc_pkg::REQ_FLUSH, 64'd0);
    send_request(wblsc_pkg::REQ_FLUSH, '1);
    send_request(wblsc_pkg::REQ_INVAL, 64'd0);
    send_request(wblsc_pkg::REQ_READ, 64'd0);
    end_burst();
    drain();

    // Tiny partition; fill all lines dirty, then evict; registers do not clear.
    write_reg(wblsc_pkg::REG_BASE, 64'd1000);
    write_reg(wblsc_pkg::REG_SIZE, 64'd40);
    for (int i = 0; i < 34; i++) send_request(wblsc_pkg::REQ_WRITE, 64'(i));
    send_request(wblsc_pkg::REQ_READ, 64'd40);
    end_burst();
    drain();

    // Long receiver hold-off while requests keep coming.
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        for (int i = 0; i < 6; i++)
          send_request(wblsc_pkg::REQ_WRITE, 64'($urandom_range(0, 39)));
        end_burst();
      end
    join
    drain();

    // Random phases with varied register settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: size_v = 64'd48;
        1: size_v = 64'd1;
        2: size_v = 64'd64;
        default: size_v = rand64();
      endcase
      write_reg(wblsc_pkg::REG_BASE, rand64());
      write_reg(wblsc_pkg::REG_SIZE, size_v);
      if (ph == 3) quiet_phase = 1'b1;
      for (int i = 0; i < 12; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_request(rand_kind(), rand64());
        else if (ph == 3)
          send_request(rand_kind(), rand64() % size_v);
        else
          send_request(rand_kind(), 64'($urandom_range(0, 70)));
      end
      end_burst();
      drain();
    end

    write_reg(wblsc_pkg::REG_ENABLE, 64'd0);
    send_request(wblsc_pkg::REQ_FLUSH, 64'd0);
    end_burst();
    drain();

    if (fail_count == 0)
      $display("write_back_lru_sector_cache_ctrl verification clean");
    else
      $display("write_back_lru_sector_cache_ctrl verification failed");
    $finish;
  end
endmodule
`default_nettype wire
